@@ design/tgad_pkg.sv @@
`timescale 1ns / 1ps
// Package for the TGA stream decoder: result record, queue push bundle,
// parse phases and field codes. No dependencies.
package tgad_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_PKT,
        PH_PIX,
        PH_IDLE
    } phase_t;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PIX = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CMAP    = 3'd1;
    localparam logic [2:0] ERR_TYPE    = 3'd2;
    localparam logic [2:0] ERR_DEPTH   = 3'd3;
    localparam logic [2:0] ERR_ALPHA   = 3'd4;
    localparam logic [2:0] ERR_TRUNC   = 3'd5;
    localparam logic [2:0] ERR_OVERRUN = 3'd6;

    localparam logic [1:0] IMG_GRAY   = 2'd0;
    localparam logic [1:0] IMG_TRUE   = 2'd1;
    localparam logic [1:0] IMG_TRUE32 = 2'd2;

    // header byte offsets
    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_CMAP      = 5'd1;
    localparam logic [4:0] HB_TYPE      = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_DEPTH     = 5'd16;
    localparam logic [4:0] HB_DESC      = 5'd17;

    localparam logic [7:0] TYPE_TRUE     = 8'd2;
    localparam logic [7:0] TYPE_GRAY     = 8'd3;
    localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
    localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;
    localparam logic [7:0] CMAP_PRESENT  = 8'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pixel;
        logic [7:0]  run;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  img_kind;
        logic [2:0]  bpp;
        logic [2:0]  err;
        logic        done;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       rec0;
        res_t       rec1;
    } push_t;

endpackage

@@ design/tgad_front.sv @@
`timescale 1ns / 1ps
// Front end: takes file bytes, parses header and pixel packets, and pushes
// zero to two result records per byte. Depends on tgad_pkg.
module tgad_front import tgad_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_first,
    input  logic       in_final,
    input  logic       q_space,
    output logic       in_ready,
    output push_t      push
);

    phase_t      phase_reg, phase_next, phase_pre, cur_phase;
    logic [4:0]  idx_reg, idx_next, cur_idx;
    logic [7:0]  id_left_reg, id_left_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [2:0]  depth_reg, depth_next;
    logic [1:0]  kind_reg, kind_next;
    logic        rle_reg, rle_next;
    logic        rep_reg, rep_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  pix_idx_reg, pix_idx_next;
    logic [31:0] pixels_left_reg, pixels_left_next;

    logic        accept;
    logic [31:0] prod;
    logic        prod_zero;
    logic [7:0]  id_dec;
    logic [7:0]  pkt_count;
    logic        pkt_over;
    logic [31:0] shift_new;
    logic        pix_done;
    logic [31:0] pix_out;
    logic        run_rep;
    logic [7:0]  run;
    logic [7:0]  pkt_after;
    logic [31:0] pixels_after;
    logic        type_ok;
    logic        depth_ok;
    logic        alpha_ok;

    logic        prim_v;
    res_t        prim;
    res_t        trunc_rec;
    logic        trunc_v;

    assign in_ready  = q_space;
    assign accept    = in_valid && q_space;
    assign cur_phase = in_first ? PH_HEADER : phase_reg;
    assign cur_idx   = in_first ? HB_ID_LEN : idx_reg;

    assign prod      = width_reg * height_reg;
    assign prod_zero = (width_reg == 16'd0) || (height_reg == 16'd0);
    assign id_dec    = id_left_reg - 8'd1;
    assign pkt_count = {1'b0, in_byte[6:0]} + 8'd1;
    assign pkt_over  = {24'd0, pkt_count} > pixels_left_reg;
    assign shift_new = shift_reg | ({24'd0, in_byte} << {pix_idx_reg, 3'b000});
    assign pix_done  = ({1'b0, pix_idx_reg} + 3'd1) >= depth_reg;
    assign pix_out   = (kind_reg != IMG_GRAY && depth_reg >= 3'd3)
                     ? {shift_new[31:24], shift_new[7:0], shift_new[15:8], shift_new[23:16]}
                     : shift_new;
    assign run_rep   = rle_reg && rep_reg;
    assign run       = run_rep ? pkt_left_reg : 8'd1;
    assign pkt_after = run_rep ? 8'd0 : (rle_reg ? pkt_left_reg - 8'd1 : pkt_left_reg);
    assign pixels_after = pixels_left_reg - {24'd0, run};

    assign type_ok  = (in_byte == TYPE_TRUE) || (in_byte == TYPE_GRAY) ||
                      (in_byte == TYPE_RLE_TRUE) || (in_byte == TYPE_RLE_GRAY);
    assign depth_ok = (in_byte == 8'd8) || (in_byte == 8'd16) ||
                      (in_byte == 8'd24) || (in_byte == 8'd32);
    assign alpha_ok = (in_byte[3:0] == 4'h0) || (in_byte[3:0] == 4'h8);

    // next state
    always_comb begin
        phase_pre        = cur_phase;
        idx_next         = cur_idx;
        id_left_next     = id_left_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        depth_next       = depth_reg;
        kind_next        = kind_reg;
        rle_next         = rle_reg;
        rep_next         = rep_reg;
        pkt_left_next    = pkt_left_reg;
        shift_next       = shift_reg;
        pix_idx_next     = pix_idx_reg;
        pixels_left_next = pixels_left_reg;
        case (cur_phase)
            PH_HEADER: begin
                idx_next = cur_idx + 5'd1;
                case (cur_idx)
                    HB_ID_LEN:    id_left_next = in_byte;
                    HB_CMAP: begin
                        if (in_byte == CMAP_PRESENT) phase_pre = PH_IDLE;
                    end
                    HB_TYPE: begin
                        if (!type_ok) begin
                            phase_pre = PH_IDLE;
                        end else begin
                            kind_next = (in_byte == TYPE_TRUE || in_byte == TYPE_RLE_TRUE)
                                      ? IMG_TRUE : IMG_GRAY;
                            rle_next  = in_byte >= TYPE_RLE_TRUE;
                        end
                    end
                    HB_WIDTH_LO:  width_next[7:0]   = in_byte;
                    HB_WIDTH_HI:  width_next[15:8]  = in_byte;
                    HB_HEIGHT_LO: height_next[7:0]  = in_byte;
                    HB_HEIGHT_HI: height_next[15:8] = in_byte;
                    HB_DEPTH: begin
                        if (!depth_ok) begin
                            phase_pre = PH_IDLE;
                        end else begin
                            depth_next = in_byte[5:3];
                            if (kind_reg == IMG_TRUE && in_byte == 8'd32) kind_next = IMG_TRUE32;
                        end
                    end
                    HB_DESC: begin
                        if (!alpha_ok) begin
                            phase_pre = PH_IDLE;
                        end else if (id_left_reg != 8'd0) begin
                            phase_pre = PH_ID;
                        end else begin
                            pixels_left_next = prod;
                            pix_idx_next     = 2'd0;
                            shift_next       = 32'd0;
                            pkt_left_next    = 8'd0;
                            rep_next         = 1'b0;
                            phase_pre        = prod_zero ? PH_IDLE : (rle_reg ? PH_PKT : PH_PIX);
                        end
                    end
                    default: ;
                endcase
            end
            PH_ID: begin
                id_left_next = id_dec;
                if (id_dec == 8'd0) begin
                    pixels_left_next = prod;
                    pix_idx_next     = 2'd0;
                    shift_next       = 32'd0;
                    pkt_left_next    = 8'd0;
                    rep_next         = 1'b0;
                    phase_pre        = prod_zero ? PH_IDLE : (rle_reg ? PH_PKT : PH_PIX);
                end
            end
            PH_PKT: begin
                if (pkt_over) begin
                    phase_pre = PH_IDLE;
                end else begin
                    rep_next      = in_byte[7];
                    pkt_left_next = pkt_count;
                    pix_idx_next  = 2'd0;
                    shift_next    = 32'd0;
                    phase_pre     = PH_PIX;
                end
            end
            PH_PIX: begin
                if (!pix_done) begin
                    shift_next   = shift_new;
                    pix_idx_next = pix_idx_reg + 2'd1;
                end else begin
                    shift_next       = 32'd0;
                    pix_idx_next     = 2'd0;
                    pkt_left_next    = pkt_after;
                    pixels_left_next = pixels_after;
                    if (pixels_after == 32'd0) begin
                        phase_pre = PH_IDLE;
                    end else if (rle_reg && pkt_after == 8'd0) begin
                        phase_pre = PH_PKT;
                    end
                end
            end
            default: ;
        endcase
        phase_next = (in_final && phase_pre != PH_IDLE) ? PH_IDLE : phase_pre;
    end

    // results
    always_comb begin
        prim_v = 1'b0;
        prim   = '0;
        case (cur_phase)
            PH_HEADER: begin
                case (cur_idx)
                    HB_CMAP: begin
                        if (in_byte == CMAP_PRESENT) begin
                            prim_v = 1'b1; prim.kind = KIND_ERR; prim.err = ERR_CMAP;
                        end
                    end
                    HB_TYPE: begin
                        if (!type_ok) begin
                            prim_v = 1'b1; prim.kind = KIND_ERR; prim.err = ERR_TYPE;
                        end
                    end
                    HB_DEPTH: begin
                        if (!depth_ok) begin
                            prim_v = 1'b1; prim.kind = KIND_ERR; prim.err = ERR_DEPTH;
                        end
                    end
                    HB_DESC: begin
                        if (!alpha_ok) begin
                            prim_v = 1'b1; prim.kind = KIND_ERR; prim.err = ERR_ALPHA;
                        end else if (id_left_reg == 8'd0) begin
                            prim_v = 1'b1;
                            prim.kind = KIND_HDR;
                            prim.done = prod_zero;
                        end
                    end
                    default: ;
                endcase
            end
            PH_ID: begin
                if (id_dec == 8'd0) begin
                    prim_v = 1'b1;
                    prim.kind = KIND_HDR;
                    prim.done = prod_zero;
                end
            end
            PH_PKT: begin
                if (pkt_over) begin
                    prim_v = 1'b1; prim.kind = KIND_ERR; prim.err = ERR_OVERRUN;
                end
            end
            PH_PIX: begin
                if (pix_done) begin
                    prim_v = 1'b1;
                    prim.kind  = KIND_PIX;
                    prim.pixel = pix_out;
                    prim.run   = run;
                    prim.done  = pixels_after == 32'd0;
                end
            end
            default: ;
        endcase
        if (prim_v && prim.kind != KIND_ERR) begin
            prim.width    = width_reg;
            prim.height   = height_reg;
            prim.img_kind = kind_reg;
            prim.bpp      = depth_reg;
        end
        trunc_rec      = '0;
        trunc_rec.kind = KIND_ERR;
        trunc_rec.err  = ERR_TRUNC;
        trunc_v        = in_final && phase_pre != PH_IDLE;

        push = '0;
        if (accept) begin
            if (prim_v) begin
                push.rec0  = prim;
                push.rec1  = trunc_rec;
                push.count = trunc_v ? 2'd2 : 2'd1;
            end else begin
                push.rec0  = trunc_rec;
                push.count = trunc_v ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            idx_reg         <= '0;
            id_left_reg     <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            depth_reg       <= '0;
            kind_reg        <= '0;
            rle_reg         <= 1'b0;
            rep_reg         <= 1'b0;
            pkt_left_reg    <= '0;
            shift_reg       <= '0;
            pix_idx_reg     <= '0;
            pixels_left_reg <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            id_left_reg     <= id_left_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            depth_reg       <= depth_next;
            kind_reg        <= kind_next;
            rle_reg         <= rle_next;
            rep_reg         <= rep_next;
            pkt_left_reg    <= pkt_left_next;
            shift_reg       <= shift_next;
            pix_idx_reg     <= pix_idx_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

endmodule

@@ design/tgad_queue.sv @@
`timescale 1ns / 1ps
// Result queue between front and back: two writes, one read per cycle.
// Depends on tgad_pkg.
module tgad_queue import tgad_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  pop,
    output logic  space,
    output logic  empty,
    output res_t  head
);

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign space  = count_reg <= QCNT_W'(QDEPTH - 2);
    assign empty  = count_reg == '0;
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.rec0;
        if (push.count == 2'd2) mem[wr_ptr_reg + QPTR_W'(1)] <= push.rec1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/tgad_back.sv @@
`timescale 1ns / 1ps
// Back end: output register that drains the result queue onto the
// master stream. Depends on tgad_pkg.
module tgad_back import tgad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  res_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic valid_reg, valid_next;
    res_t data_reg;
    logic load;

    assign load       = !valid_reg || m_tready;
    assign q_pop      = load && !q_empty;
    assign valid_next = load ? !q_empty : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) data_reg <= q_head;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.done;
    assign m_tdata  = {data_reg.err, data_reg.bpp, data_reg.img_kind, data_reg.height,
                       data_reg.width, data_reg.run, data_reg.pixel};

endmodule

@@ design/tga_image_stream_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the TGA stream decoder: parser front, result queue, output
// stage. Depends on tgad_pkg, tgad_front, tgad_queue, tgad_back.
//
//  channel | dir | word                | sideband
//  s_      | in  | file byte           | tuser first byte, tlast final byte
//  m_      | out | hdr/pixel run/error | tuser result kind, tlast image done
//
// One file byte per cycle while the queue has space; a byte yields zero
// to two results, the queue takes both in one cycle and the output stage
// sends one per cycle while m_tready allows. Input ready falls only while
// the four-entry queue holds three or more. Reset is synchronous, low.
module tga_image_stream_decoder import tgad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value, run_length, image_width, image_height, image_kind,
    // bytes_per_pixel, error_code
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast    // image_done
);

    push_t push;
    logic  q_space;
    logic  q_empty;
    logic  q_pop;
    res_t  q_head;

    tgad_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_first (s_tuser),
        .in_final (s_tlast),
        .q_space  (q_space),
        .in_ready (s_tready),
        .push     (push)
    );

    tgad_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .space   (q_space),
        .empty   (q_empty),
        .head    (q_head)
    );

    tgad_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
